// ===== sv/key_debounce_long_press_top_assert.svh =====
// Assertion macros shared by the debouncer top level.
`ifndef KEY_DEBOUNCE_LONG_PRESS_TOP_ASSERT_SVH
`define KEY_DEBOUNCE_LONG_PRESS_TOP_ASSERT_SVH

`ifndef SYNTH
`define KDLP_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");
`define KDLP_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define KDLP_ASSERT_SAME(label, ante, cons)
`define KDLP_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== sv/kdlp_pkg.sv =====
`timescale 1ns / 1ps
package kdlp_pkg;

   localparam int NUM_KEYS    = 2;
   localparam int KEY_INDEX_W = 1;
   localparam int COUNT_W     = 16;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [COUNT_W-1:0] HOLD_MAX = 16'hffff;

   typedef enum logic [1:0] {
      EV_NONE    = 2'd0,
      EV_PRESS   = 2'd1,
      EV_LONG    = 2'd2,
      EV_RELEASE = 2'd3
   } ev_type;

   typedef enum logic [0:0] {
      KIND_SCAN  = 1'b0,
      KIND_CLEAR = 1'b1
   } kind_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_ACTIVE_LEVEL = 2'd0,
      REG_DEBOUNCE     = 2'd1,
      REG_LONG_PRESS   = 2'd2,
      REG_UNUSED       = 2'd3
   } reg_index_type;

   typedef struct packed {
      kind_type                kind;
      logic [NUM_KEYS-1:0]     key_levels;
      logic [KEY_INDEX_W-1:0]  key_index;
   } req_type;

   typedef struct packed {
      logic [2*NUM_KEYS-1:0]   key_events;
      logic [NUM_KEYS-1:0]     key_confirmed;
   } rsp_type;

   typedef struct packed {
      logic                active_level;
      logic [COUNT_W-1:0]  debounce_ticks;
      logic [COUNT_W-1:0]  long_press_ticks;
   } cfg_type;

   typedef struct packed {
      ev_type  event_code;
      logic    confirmed;
   } lane_status_type;

endpackage

// ===== sv/kdlp_lane.sv =====
`timescale 1ns / 1ps
module kdlp_lane (
   input  logic                      clock,
   input  logic                      reset,
   input  kdlp_pkg::cfg_type         cfg,
   input  logic                      scan_en,
   input  logic                      clear_en,
   input  logic                      level,
   output kdlp_pkg::lane_status_type status_next
);
   import kdlp_pkg::*;

   logic [COUNT_W-1:0] count_ff, count_in;
   logic               conf_ff, conf_in;
   logic               long_ff, long_in;
   ev_type             event_ff, event_in;
   logic [COUNT_W-1:0] count_inc;
   logic               pressed;

   assign pressed   = (level == cfg.active_level);
   assign count_inc = (count_ff != HOLD_MAX) ? count_ff + COUNT_W'(1) : count_ff;

   always_comb begin
      count_in = count_ff;
      conf_in  = conf_ff;
      long_in  = long_ff;
      event_in = event_ff;
      if (scan_en) begin
         if (pressed) begin
            count_in = count_inc;
            // On the confirm tick no long-press check is made.
            if (count_inc == cfg.debounce_ticks) begin
               conf_in = 1'b1;
            end else if (count_inc >= cfg.long_press_ticks && !long_ff) begin
               event_in = EV_LONG;
               long_in  = 1'b1;
            end
         end else begin
            if (conf_ff) begin
               if (count_ff >= cfg.debounce_ticks && count_ff < cfg.long_press_ticks) begin
                  event_in = EV_PRESS;
               end else if (long_ff) begin
                  event_in = EV_RELEASE;
               end
               conf_in = 1'b0;
            end
            count_in = '0;
            long_in  = 1'b0;
         end
      end else if (clear_en) begin
         event_in = EV_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         conf_ff  <= 1'b0;
         long_ff  <= 1'b0;
         event_ff <= EV_NONE;
      end else begin
         count_ff <= count_in;
         conf_ff  <= conf_in;
         long_ff  <= long_in;
         event_ff <= event_in;
      end
   end

   assign status_next.event_code = event_in;
   assign status_next.confirmed  = conf_in;

endmodule

// ===== sv/kdlp_merge.sv =====
`timescale 1ns / 1ps
module kdlp_merge (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  kdlp_pkg::lane_status_type lane_status [kdlp_pkg::NUM_KEYS],
   output logic                      push_ready,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output kdlp_pkg::rsp_type         rsp_data
);
   import kdlp_pkg::*;

   rsp_type packed_rsp;
   rsp_type out_data_ff, out_data_in;
   rsp_type skid_data_ff, skid_data_in;
   logic    out_valid_ff, out_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   logic    pop;

   always_comb begin
      packed_rsp = '0;
      for (int k = 0; k < NUM_KEYS; k++) begin
         packed_rsp.key_events[2*k +: 2] = lane_status[k].event_code;
         packed_rsp.key_confirmed[k]     = lane_status[k].confirmed;
      end
   end

   assign pop = out_valid_ff && rsp_ready;

   // The skid stage takes an item while the output register is still waiting.
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || pop) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = push;
            out_data_in  = packed_rsp;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_data_in  = packed_rsp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign push_ready = !skid_valid_ff;
   assign rsp_valid  = out_valid_ff;
   assign rsp_data   = out_data_ff;

endmodule

// ===== sv/key_debounce_long_press_top.sv =====
// A result is registered in the output stage, or in the skid stage while the output waits.
// Throughput: one item per cycle while the skid stage is empty; each key has its own lane.
// A two-deep output buffer lets an item enter while one result still waits.
// Reset (synchronous, active high) clears all key state, events and the output buffer,
// and restores the registers to active level 0, debounce 3 and long press 100.
`timescale 1ns / 1ps
`include "key_debounce_long_press_top_assert.svh"
module key_debounce_long_press_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  kdlp_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output kdlp_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_wr_en,
   input  logic [kdlp_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [kdlp_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import kdlp_pkg::*;

   cfg_type         cfg_ff, cfg_in;
   logic            accept;
   logic            scan_en;
   logic            clear_en;
   lane_status_type lane_status [NUM_KEYS];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (reg_index_type'(csr_index))
            REG_ACTIVE_LEVEL: cfg_in.active_level     = csr_wdata[0];
            REG_DEBOUNCE:     cfg_in.debounce_ticks   = csr_wdata[COUNT_W-1:0];
            REG_LONG_PRESS:   cfg_in.long_press_ticks = csr_wdata[COUNT_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.active_level     <= 1'b0;
         cfg_ff.debounce_ticks   <= COUNT_W'(3);
         cfg_ff.long_press_ticks <= COUNT_W'(100);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign accept   = req_valid && req_ready;
   assign scan_en  = accept && (req_data.kind == KIND_SCAN);
   assign clear_en = accept && (req_data.kind == KIND_CLEAR);

   for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
      kdlp_lane u_lane (
         .clock       (clock),
         .reset       (reset),
         .cfg         (cfg_ff),
         .scan_en     (scan_en),
         .clear_en    (clear_en && (32'(req_data.key_index) == k)),
         .level       (req_data.key_levels[k]),
         .status_next (lane_status[k])
      );
   end

   kdlp_merge u_merge (
      .clock       (clock),
      .reset       (reset),
      .push        (accept),
      .lane_status (lane_status),
      .push_ready  (req_ready),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

   `KDLP_ASSERT_NEXT(a_accept_gives_result, accept, rsp_valid)
   `KDLP_ASSERT_SAME(a_stall_only_when_full, !req_ready, rsp_valid)
   `KDLP_ASSERT_NEXT(a_full_holds_until_taken, !req_ready && !rsp_ready, !req_ready)

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
module tb;
   import kdlp_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int SQUEEZE_CYCLES = 80;

   typedef struct packed {
      logic    typed;
      rsp_type val;
   } typed_rsp_type;

   typedef struct {
      req_type req;
      logic    typed;
      rsp_type rsp;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // Shadow copy of the debouncer: registers and per-key state.
   cfg_type model_cfg;
   logic [COUNT_W-1:0] key_hold [NUM_KEYS];
   logic key_conf [NUM_KEYS];
   logic key_long [NUM_KEYS];
   ev_type key_event [NUM_KEYS];

   rsp_type status_q[$];
   typed_rsp_type fixed_q[$];
   int fail_count = 0;
   int cycle_count = 0;
   bit send_idle = 1'b1;
   bit recv_idle = 1'b1;
   bit squeeze_req = 1'b0;

   key_debounce_long_press_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #10 clock = ~clock;

   function automatic void model_reset();
      model_cfg.active_level = 1'b0;
      model_cfg.debounce_ticks = 16'd3;
      model_cfg.long_press_ticks = 16'd100;
      for (int k = 0; k < NUM_KEYS; k++) begin
         key_hold[k] = '0;
         key_conf[k] = 1'b0;
         key_long[k] = 1'b0;
         key_event[k] = EV_NONE;
      end
   endfunction

   // Advances the shadow state by one item and returns the status it leaves behind.
   function automatic rsp_type debounce_step(req_type r);
      rsp_type res;
      if (r.kind == KIND_SCAN) begin
         for (int k = 0; k < NUM_KEYS; k++) begin
            if (r.key_levels[k] == model_cfg.active_level) begin
               if (key_hold[k] != HOLD_MAX) key_hold[k] = key_hold[k] + 1'b1;
               if (key_hold[k] == model_cfg.debounce_ticks) begin
                  key_conf[k] = 1'b1;
               end else if (key_hold[k] >= model_cfg.long_press_ticks && !key_long[k]) begin
                  key_event[k] = EV_LONG;
                  key_long[k] = 1'b1;
               end
            end else begin
               if (key_conf[k]) begin
                  if (key_hold[k] >= model_cfg.debounce_ticks &&
                      key_hold[k] < model_cfg.long_press_ticks) begin
                     key_event[k] = EV_PRESS;
                  end else if (key_long[k]) begin
                     key_event[k] = EV_RELEASE;
                  end
                  key_conf[k] = 1'b0;
               end
               key_hold[k] = '0;
               key_long[k] = 1'b0;
            end
         end
      end else if (int'(r.key_index) < NUM_KEYS) begin
         key_event[r.key_index] = EV_NONE;
      end
      for (int k = 0; k < NUM_KEYS; k++) begin
         res.key_events[2*k +: 2] = key_event[k];
         res.key_confirmed[k] = key_conf[k];
      end
      return res;
   endfunction

   // Register writes and accepted items, both seen at the clock edge.
   always @(posedge clock) begin
      typed_rsp_type fix;
      rsp_type pred;
      if (reset) begin
         model_reset();
      end else begin
         if (csr_wr_en) begin
            case (reg_index_type'(csr_index))
               REG_ACTIVE_LEVEL: model_cfg.active_level = csr_wdata[0];
               REG_DEBOUNCE:     model_cfg.debounce_ticks = csr_wdata;
               REG_LONG_PRESS:   model_cfg.long_press_ticks = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            pred = debounce_step(req_data);
            fix = '0;
            if (fixed_q.size() != 0) fix = fixed_q.pop_front();
            status_q.push_back(fix.typed ? fix.val : pred);
         end
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (status_q.size() == 0) begin
            $display("%0t: unexpected result %h", $time, rsp_data);
            fail_count++;
         end else begin
            want = status_q.pop_front();
            if (rsp_data.key_events !== want.key_events) begin
               $display("%0t: key_events expected %h actual %h", $time,
                        want.key_events, rsp_data.key_events);
               fail_count++;
            end
            if (rsp_data.key_confirmed !== want.key_confirmed) begin
               $display("%0t: key_confirmed expected %h actual %h", $time,
                        want.key_confirmed, rsp_data.key_confirmed);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // Result side: short random stalls, and one long hold-off on request.
   initial begin
      rsp_ready <= 1'b1;
      forever begin
         @(posedge clock);
         if (squeeze_req) begin
            squeeze_req = 1'b0;
            rsp_ready <= 1'b0;
            repeat (SQUEEZE_CYCLES) @(posedge clock);
            rsp_ready <= 1'b1;
         end else if (recv_idle && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clock);
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic send_item(req_type r, logic typed, rsp_type val);
      if (send_idle && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      fixed_q.push_back('{typed, val});
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (status_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(reg_index_type idx, logic [CSR_DATA_W-1:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   task automatic set_config(logic act, int deb, int lng);
      csr_write(REG_ACTIVE_LEVEL, {{(CSR_DATA_W-1){1'b0}}, act});
      csr_write(REG_DEBOUNCE, CSR_DATA_W'(deb));
      csr_write(REG_LONG_PRESS, CSR_DATA_W'(lng));
      csr_wr_en <= 1'b0;
   endtask

   // Length of a pressed stretch, aimed mostly at the two thresholds.
   function automatic int pick_run(int deb, int lng);
      int lo;
      int hi;
      case ($urandom_range(0, 4))
         0: begin lo = 1; hi = deb + 1; end
         1: begin lo = deb; hi = deb + 2; end
         2: begin lo = lng - 1; hi = lng + 2; end
         3: begin lo = 1; hi = 10; end
         default: begin lo = (deb > lng ? deb : lng) + 1; hi = lo + 3; end
      endcase
      if (lo < 1) lo = 1;
      if (lo > 150) lo = 150;
      if (hi < lo) hi = lo;
      if (hi > 150) hi = 150;
      return $urandom_range(lo, hi);
   endfunction

   task automatic run_phase(logic act, int deb, int lng, int n, bit squeeze);
      int left [NUM_KEYS];
      bit held [NUM_KEYS];
      req_type r;
      int sel;
      drain();
      set_config(act, deb, lng);
      for (int k = 0; k < NUM_KEYS; k++) begin
         left[k] = 0;
         held[k] = 1'b0;
      end
      if (squeeze) squeeze_req = 1'b1;
      repeat (n) begin
         sel = $urandom_range(0, 99);
         r.kind = KIND_SCAN;
         r.key_levels = '0;
         r.key_index = KEY_INDEX_W'($urandom_range(0, 1));
         if (sel < 12) begin
            r.kind = KIND_CLEAR;
            r.key_levels = NUM_KEYS'($urandom_range(0, 2**NUM_KEYS - 1));
         end else if (sel < 20) begin
            r.key_levels = NUM_KEYS'($urandom_range(0, 2**NUM_KEYS - 1));
         end else begin
            // Well-formed presses and releases, each key on its own schedule.
            for (int k = 0; k < NUM_KEYS; k++) begin
               if (left[k] == 0) begin
                  held[k] = !held[k];
                  left[k] = held[k] ? pick_run(deb, lng) : $urandom_range(1, 4);
               end
               left[k]--;
               r.key_levels[k] = held[k] ? act : !act;
            end
         end
         send_item(r, 1'b0, '0);
      end
   endtask

   // Key 0 is held for a long stretch with the long press set below the debounce count,
   // so the long press comes first and confirmation follows later.
   task automatic run_long_hold();
      req_type r;
      drain();
      set_config(1'b1, 250, 200);
      for (int i = 0; i < 300; i++) begin
         r.kind = KIND_SCAN;
         r.key_index = KEY_INDEX_W'($urandom_range(0, 1));
         r.key_levels = {1'($urandom_range(0, 1)), 1'b1};
         if (i % 64 == 32) r.kind = KIND_CLEAR;
         if (i >= 295) r.key_levels[0] = 1'b0;
         send_item(r, 1'b0, '0);
      end
   endtask

   dir_row_type dir_tab [19];

   initial begin
      dir_tab = '{
         '{'{KIND_CLEAR, 2'b11, 1'b0}, 1'b1, '{4'h0, 2'b00}},
         '{'{KIND_CLEAR, 2'b00, 1'b1}, 1'b1, '{4'h0, 2'b00}},
         '{'{KIND_SCAN,  2'b11, 1'b0}, 1'b1, '{4'h0, 2'b00}},
         '{'{KIND_SCAN,  2'b00, 1'b1}, 1'b1, '{4'h0, 2'b00}},
         '{'{KIND_SCAN,  2'b00, 1'b0}, 1'b1, '{4'h0, 2'b00}},
         '{'{KIND_SCAN,  2'b00, 1'b0}, 1'b1, '{4'h0, 2'b11}},
         '{'{KIND_SCAN,  2'b10, 1'b0}, 1'b0, '0},
         '{'{KIND_SCAN,  2'b10, 1'b1}, 1'b0, '0},
         '{'{KIND_CLEAR, 2'b01, 1'b1}, 1'b0, '0},
         '{'{KIND_SCAN,  2'b01, 1'b0}, 1'b0, '0},
         '{'{KIND_SCAN,  2'b11, 1'b0}, 1'b0, '0},
         '{'{KIND_SCAN,  2'b00, 1'b0}, 1'b0, '0},
         '{'{KIND_SCAN,  2'b11, 1'b1}, 1'b0, '0},
         '{'{KIND_CLEAR, 2'b10, 1'b0}, 1'b0, '0},
         '{'{KIND_CLEAR, 2'b01, 1'b1}, 1'b1, '{4'h0, 2'b00}},
         '{'{KIND_SCAN,  2'b10, 1'b0}, 1'b0, '0},
         '{'{KIND_SCAN,  2'b10, 1'b0}, 1'b0, '0},
         '{'{KIND_SCAN,  2'b10, 1'b1}, 1'b0, '0},
         '{'{KIND_SCAN,  2'b11, 1'b0}, 1'b0, '0}
      };
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (dir_tab[i]) send_item(dir_tab[i].req, dir_tab[i].typed, dir_tab[i].rsp);

      run_phase(1'b1, 2, 6, 200, 1'b1);
      run_phase(1'b0, 5, 3, 200, 1'b0);
      run_phase(1'b1, 4, 4, 200, 1'b0);
      run_phase(1'b0, 1, 1, 150, 1'b0);
      run_phase(1'b1, 0, 0, 100, 1'b0);
      run_phase(1'b0, 0, 5, 100, 1'b0);
      run_phase(1'b1, 1, 65535, 120, 1'b0);
      run_phase(1'b0, 3, 100, 150, 1'b0);

      send_idle = 1'b0;
      recv_idle = 1'b0;
      run_long_hold();
      run_phase(1'b1, 3, 10, 100, 1'b0);
      drain();

      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/kdlp_pkg.sv
sv/kdlp_lane.sv
sv/kdlp_merge.sv
sv/key_debounce_long_press_top.sv
test/tb.sv
